// ----- rtl/core/kdas_pkg.sv -----
// kdas_pkg: shared types and constants for the keypad scanner
// no dependencies
package kdas_pkg;

  localparam int unsigned KeyCount    = 9;
  localparam int unsigned DebounceMax = 16;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned CfgDataW    = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPressStep         = 4'd0,
    CfgReleaseStep       = 4'd1,
    CfgUpperPressLevel   = 4'd2,
    CfgUpperReleaseLevel = 4'd3,
    CfgLowerPressLevel   = 4'd4,
    CfgLowerReleaseLevel = 4'd5,
    CfgRepeatDelay       = 4'd6,
    CfgRepeatPeriod      = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  press_step;
    logic [7:0]  release_step;
    logic [11:0] upper_press_level;
    logic [11:0] upper_release_level;
    logic [11:0] lower_press_level;
    logic [11:0] lower_release_level;
    logic [15:0] repeat_delay;
    logic [15:0] repeat_period;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  raw_buttons;
    logic [11:0] axis_x;
    logic [11:0] axis_y;
  } scan_t;

  typedef struct packed {
    logic [KeyCount-1:0] mask;
    logic [KeyCount-1:0] held;
  } press_t;

  localparam logic [6:0] KeyAscii [KeyCount] = '{
    7'h31, 7'h32, 7'h41, 7'h42, 7'h53, 7'h52, 7'h4C, 7'h55, 7'h44
  };

endpackage

// ----- rtl/core/kdas_if.sv -----
// kdas_if: handshake channel interfaces for scan items, key codes and config
// depends on kdas_pkg
interface kdas_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  raw_buttons;
  logic [11:0] axis_x;
  logic [11:0] axis_y;
  modport source (output valid, raw_buttons, axis_x, axis_y, input ready);
  modport sink (input valid, raw_buttons, axis_x, axis_y, output ready);
endinterface

interface kdas_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] key_code;
  logic [8:0] held_keys;
  logic       last_code;
  modport source (output valid, key_code, held_keys, last_code, input ready);
  modport sink (input valid, key_code, held_keys, last_code, output ready);
endinterface

interface kdas_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kdas_pkg::CfgIdxW-1:0]  index;
  logic [kdas_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/kdas_cfg.sv -----
// kdas_cfg: configuration register file with write decode
// depends on kdas_pkg and kdas_cfg_if
module kdas_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  kdas_cfg_if.sink        cfg_i,
  output kdas_pkg::cfg_t  cfg_o
);

  kdas_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        kdas_pkg::CfgPressStep:         cfg_d.press_step          = cfg_i.data[7:0];
        kdas_pkg::CfgReleaseStep:       cfg_d.release_step        = cfg_i.data[7:0];
        kdas_pkg::CfgUpperPressLevel:   cfg_d.upper_press_level   = cfg_i.data[11:0];
        kdas_pkg::CfgUpperReleaseLevel: cfg_d.upper_release_level = cfg_i.data[11:0];
        kdas_pkg::CfgLowerPressLevel:   cfg_d.lower_press_level   = cfg_i.data[11:0];
        kdas_pkg::CfgLowerReleaseLevel: cfg_d.lower_release_level = cfg_i.data[11:0];
        kdas_pkg::CfgRepeatDelay:       cfg_d.repeat_delay        = cfg_i.data[15:0];
        kdas_pkg::CfgRepeatPeriod:      cfg_d.repeat_period       = cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_step          <= 8'd1;
      cfg_q.release_step        <= 8'd1;
      cfg_q.upper_press_level   <= 12'd3000;
      cfg_q.upper_release_level <= 12'd2600;
      cfg_q.lower_press_level   <= 12'd1000;
      cfg_q.lower_release_level <= 12'd1400;
      cfg_q.repeat_delay        <= 16'd100;
      cfg_q.repeat_period       <= 16'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/core/kdas_core.sv -----
// kdas_core: debounce counters, joystick hysteresis and autorepeat state
// one scan item is folded into the state per step; depends on kdas_pkg
module kdas_core #(
  parameter int unsigned RawButtons = 5,
  parameter int unsigned HoldBits   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  kdas_pkg::scan_t  scan_i,
  input  kdas_pkg::cfg_t   cfg_i,
  output kdas_pkg::press_t press_o
);

  localparam int unsigned Keys = kdas_pkg::KeyCount;
  localparam int unsigned CmpW = (HoldBits > 16) ? HoldBits : 16;
  localparam logic [8:0]  DebMax = 9'(kdas_pkg::DebounceMax);

  logic [7:0]          level_q [RawButtons];
  logic [7:0]          level_d [RawButtons];
  logic [Keys-1:0]     held_q, held_d;
  logic [HoldBits-1:0] hold_q [Keys];
  logic [HoldBits-1:0] hold_d [Keys];
  logic [15:0]         phase_q [Keys];
  logic [15:0]         phase_d [Keys];
  logic [Keys-1:0]     mask;
  logic [15:0]         period;

  assign period = (cfg_i.repeat_period == 16'd0) ? 16'd1 : cfg_i.repeat_period;

  always_comb begin
    logic [8:0]  lv;
    logic [16:0] ph1;
    lv     = '0;
    ph1    = '0;
    held_d = held_q;
    for (int i = 0; i < RawButtons; i++) begin
      level_d[i] = level_q[i];
      if (scan_i.raw_buttons[i]) begin
        lv = {1'b0, level_q[i]} + {1'b0, cfg_i.press_step};
        if (lv >= DebMax) begin
          level_d[i] = DebMax[7:0];
          held_d[i]  = 1'b1;
        end else begin
          level_d[i] = lv[7:0];
        end
      end else if (cfg_i.release_step >= level_q[i]) begin
        level_d[i] = 8'd0;
        held_d[i]  = 1'b0;
      end else begin
        level_d[i] = level_q[i] - cfg_i.release_step;
      end
    end
    // x axis: right then left, y axis: up then down
    if (scan_i.axis_x > cfg_i.upper_press_level)   held_d[5] = 1'b1;
    if (scan_i.axis_x < cfg_i.upper_release_level) held_d[5] = 1'b0;
    if (scan_i.axis_x < cfg_i.lower_press_level)   held_d[6] = 1'b1;
    if (scan_i.axis_x > cfg_i.lower_release_level) held_d[6] = 1'b0;
    if (scan_i.axis_y > cfg_i.upper_press_level)   held_d[7] = 1'b1;
    if (scan_i.axis_y < cfg_i.upper_release_level) held_d[7] = 1'b0;
    if (scan_i.axis_y < cfg_i.lower_press_level)   held_d[8] = 1'b1;
    if (scan_i.axis_y > cfg_i.lower_release_level) held_d[8] = 1'b0;

    mask = ~held_q & held_d;
    for (int k = 0; k < Keys; k++) begin
      hold_d[k]  = hold_q[k];
      phase_d[k] = phase_q[k];
      if (held_d[k]) begin
        if (hold_q[k] != {HoldBits{1'b1}}) hold_d[k] = hold_q[k] + 1'b1;
        if (CmpW'(hold_d[k]) >= CmpW'(cfg_i.repeat_delay)) begin
          if (phase_q[k] == 16'd0) mask[k] = 1'b1;
          ph1 = {1'b0, phase_q[k]} + 17'd1;
          phase_d[k] = (ph1 >= {1'b0, period}) ? 16'd0 : ph1[15:0];
        end else begin
          phase_d[k] = 16'd0;
        end
      end else begin
        hold_d[k]  = '0;
        phase_d[k] = 16'd0;
      end
    end
  end

  assign press_o.mask = mask;
  assign press_o.held = held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      for (int i = 0; i < RawButtons; i++) level_q[i] <= 8'd0;
      for (int k = 0; k < Keys; k++) begin
        hold_q[k]  <= '0;
        phase_q[k] <= 16'd0;
      end
    end else if (step_i) begin
      held_q <= held_d;
      for (int i = 0; i < RawButtons; i++) level_q[i] <= level_d[i];
      for (int k = 0; k < Keys; k++) begin
        hold_q[k]  <= hold_d[k];
        phase_q[k] <= phase_d[k];
      end
    end
  end

endmodule

// ----- rtl/core/kdas_ser.sv -----
// kdas_ser: holds one tick's press mask and emits one key code per cycle while out_o is
// ready, lowest key first; depends on kdas_pkg and kdas_out_if
module kdas_ser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  kdas_pkg::press_t press_i,
  output logic             free_o,
  kdas_out_if.source       out_o
);

  localparam int unsigned Keys = kdas_pkg::KeyCount;

  logic [Keys-1:0] mask_q, mask_d;
  logic [Keys-1:0] held_q;
  logic [Keys-1:0] low, rest;
  logic [3:0]      sel;
  logic            pop, out_free;
  logic            ovalid_q, ovalid_d;
  logic [6:0]      code_q;
  logic [8:0]      okeys_q;
  logic            last_q;

  assign low      = mask_q & (~mask_q + 1'b1);
  assign rest     = mask_q & ~low;
  assign out_free = !ovalid_q || out_o.ready;
  assign pop      = out_free && (mask_q != '0);
  assign free_o   = (mask_q == '0) || (pop && (rest == '0));

  always_comb begin
    sel = 4'd0;
    for (int k = Keys - 1; k >= 0; k--) begin
      if (mask_q[k]) sel = 4'(k);
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = press_i.mask;
    end else if (pop) begin
      mask_d = rest;
    end
    ovalid_d = ovalid_q;
    if (pop) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      mask_q   <= mask_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) held_q <= press_i.held;
    if (pop) begin
      code_q  <= kdas_pkg::KeyAscii[sel];
      okeys_q <= held_q;
      last_q  <= (rest == '0);
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.key_code  = code_q;
  assign out_o.held_keys = okeys_q;
  assign out_o.last_code = last_q;

endmodule

// ----- rtl/core/keypad_debounce_autorepeat_scanner_top.sv -----
// keypad scanner top: input register, state update, key code serializer
// throughput: one scan item per cycle; an item's presses hold the queue until emitted
// the serializer, one key code per cycle while out_o is ready, sets the rate
// reset: asynchronous active low, clears all counters, key state and config to defaults
// depends on kdas_pkg, kdas_if, kdas_cfg, kdas_core, kdas_ser
module keypad_debounce_autorepeat_scanner_top #(
  parameter int unsigned RawButtons = 5,
  parameter int unsigned HoldBits   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kdas_in_if.sink    in_i,
  kdas_out_if.source out_o,
  kdas_cfg_if.sink   cfg_i
);

  kdas_pkg::cfg_t   cfg;
  kdas_pkg::scan_t  scan_q;
  kdas_pkg::press_t press;
  logic             in_valid_q, in_valid_d;
  logic             load, free;

  assign load       = in_valid_q && free;
  assign in_i.ready = !in_valid_q || load;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_i.valid && in_i.ready) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      scan_q.raw_buttons <= in_i.raw_buttons;
      scan_q.axis_x      <= in_i.axis_x;
      scan_q.axis_y      <= in_i.axis_y;
    end
  end

  kdas_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  kdas_core #(
    .RawButtons (RawButtons),
    .HoldBits   (HoldBits)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (load),
    .scan_i  (scan_q),
    .cfg_i   (cfg),
    .press_o (press)
  );

  kdas_ser u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .press_i (press),
    .free_o  (free),
    .out_o   (out_o)
  );

endmodule

// ----- verif/key_code_checker.sv -----
`timescale 1ns / 100ps
// key_code_checker: watches the scan, key code and config channels, keeps its own
// copy of the scanner state and settings, predicts key codes and compares them
// depends on kdas_pkg and kdas_if
module key_code_checker #(
  parameter int unsigned RawButtons = 5,
  parameter int unsigned HoldBits   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kdas_in_if          scan_mon,
  kdas_out_if         key_mon,
  kdas_cfg_if         cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import kdas_pkg::*;

  localparam int unsigned KeyRight = 5;
  localparam int unsigned KeyLeft  = 6;
  localparam int unsigned KeyUp    = 7;
  localparam int unsigned KeyDown  = 8;
  localparam longint unsigned HoldMax = (64'd1 << HoldBits) - 1;

  typedef struct packed {
    logic [6:0]          code;
    logic [KeyCount-1:0] held;
    logic                last;
  } key_event_t;

  cfg_t                settings;
  logic [7:0]          level [RawButtons];
  logic [KeyCount-1:0] held_keys;
  int unsigned         hold_count [KeyCount];
  int unsigned         repeat_phase [KeyCount];
  key_event_t          due_codes [$];
  int unsigned         fail_count = 0;

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    fail_count++;
    $display("%0t ns mismatch: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic restore_defaults();
    settings.press_step          = 8'd1;
    settings.release_step        = 8'd1;
    settings.upper_press_level   = 12'd3000;
    settings.upper_release_level = 12'd2600;
    settings.lower_press_level   = 12'd1000;
    settings.lower_release_level = 12'd1400;
    settings.repeat_delay        = 16'd100;
    settings.repeat_period       = 16'd10;
    for (int b = 0; b < RawButtons; b++) level[b] = 8'd0;
    held_keys = '0;
    for (int k = 0; k < KeyCount; k++) begin
      hold_count[k]   = 0;
      repeat_phase[k] = 0;
    end
    due_codes.delete();
  endtask

  task automatic write_setting(input logic [CfgIdxW-1:0] idx,
                               input logic [CfgDataW-1:0] data);
    case (idx)
      CfgPressStep:         settings.press_step          = data[7:0];
      CfgReleaseStep:       settings.release_step        = data[7:0];
      CfgUpperPressLevel:   settings.upper_press_level   = data[11:0];
      CfgUpperReleaseLevel: settings.upper_release_level = data[11:0];
      CfgLowerPressLevel:   settings.lower_press_level   = data[11:0];
      CfgLowerReleaseLevel: settings.lower_release_level = data[11:0];
      CfgRepeatDelay:       settings.repeat_delay        = data;
      CfgRepeatPeriod:      settings.repeat_period       = data;
      default: ;
    endcase
  endtask

  // clear is applied after set, so overlapping thresholds end cleared
  task automatic steer(input logic [11:0] v, input int unsigned hi, input int unsigned lo);
    if (v > settings.upper_press_level) held_keys[hi] = 1'b1;
    if (v < settings.upper_release_level) held_keys[hi] = 1'b0;
    if (v < settings.lower_press_level) held_keys[lo] = 1'b1;
    if (v > settings.lower_release_level) held_keys[lo] = 1'b0;
  endtask

  task automatic scan_tick(input logic [4:0] raw, input logic [11:0] ax,
                           input logic [11:0] ay);
    logic [KeyCount-1:0] prev;
    logic [KeyCount-1:0] hits;
    int unsigned         lv;
    int unsigned         span;
    int unsigned         total;
    int unsigned         sent;
    key_event_t          ev;
    prev = held_keys;
    span = (settings.repeat_period == 16'd0) ? 1 : settings.repeat_period;
    for (int b = 0; b < RawButtons; b++) begin
      if (raw[b]) begin
        lv = level[b] + settings.press_step;
        if (lv >= DebounceMax) begin
          lv = DebounceMax;
          held_keys[b] = 1'b1;
        end
        level[b] = lv[7:0];
      end else if (settings.release_step >= level[b]) begin
        level[b] = 8'd0;
        held_keys[b] = 1'b0;
      end else begin
        level[b] = level[b] - settings.release_step;
      end
    end
    steer(ax, KeyRight, KeyLeft);
    steer(ay, KeyUp, KeyDown);
    hits = ~prev & held_keys;
    for (int k = 0; k < KeyCount; k++) begin
      if (held_keys[k]) begin
        if (hold_count[k] < HoldMax) hold_count[k]++;
        if (hold_count[k] >= settings.repeat_delay) begin
          if (repeat_phase[k] == 0) hits[k] = 1'b1;
          repeat_phase[k]++;
          if (repeat_phase[k] >= span) repeat_phase[k] = 0;
        end else begin
          repeat_phase[k] = 0;
        end
      end else begin
        hold_count[k]   = 0;
        repeat_phase[k] = 0;
      end
    end
    total = $countones(hits);
    sent  = 0;
    for (int k = 0; k < KeyCount; k++) begin
      if (hits[k]) begin
        sent++;
        ev.code = KeyAscii[k];
        ev.held = held_keys;
        ev.last = (sent == total);
        due_codes.push_back(ev);
      end
    end
  endtask

  always @(posedge clk_i) begin
    key_event_t due;
    if (!rst_ni) begin
      restore_defaults();
    end else begin
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        write_setting(cfg_mon.index, cfg_mon.data);
      end
      if (scan_mon.valid === 1'b1 && scan_mon.ready === 1'b1) begin
        scan_tick(scan_mon.raw_buttons, scan_mon.axis_x, scan_mon.axis_y);
      end
      if (key_mon.valid === 1'b1 && key_mon.ready === 1'b1) begin
        if (due_codes.size() == 0) begin
          flag_mismatch("key code with none due", key_mon.key_code, 0);
        end else begin
          due = due_codes.pop_front();
          if (key_mon.key_code !== due.code) begin
            flag_mismatch("key_code", key_mon.key_code, due.code);
          end
          if (key_mon.held_keys !== due.held) begin
            flag_mismatch("held_keys", key_mon.held_keys, due.held);
          end
          if (key_mon.last_code !== due.last) begin
            flag_mismatch("last_code", key_mon.last_code, due.last);
          end
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= due_codes.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: drives scan items and register writes into the keypad scanner and
// stalls its key code channel; key_code_checker does the checking
// depends on kdas_pkg, kdas_if, keypad_debounce_autorepeat_scanner_top, key_code_checker
module tb_top;
  import kdas_pkg::*;

  localparam int unsigned CycleLimit    = 300000;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned DrainSlack    = 4;
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned ItemsPerPhase = 34;
  localparam int unsigned FloodItems    = 30;
  localparam logic [CfgIdxW-1:0] CfgSpare = 4'd12;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        quiet    = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  cfg_t        settings;
  logic [4:0]  pattern;
  int unsigned run_left;
  logic [11:0] stick_x;
  logic [11:0] stick_y;

  kdas_in_if  scan_ch ();
  kdas_out_if key_ch ();
  kdas_cfg_if cfg_ch ();

  keypad_debounce_autorepeat_scanner_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (scan_ch),
    .out_o  (key_ch),
    .cfg_i  (cfg_ch)
  );

  key_code_checker key_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scan_mon     (scan_ch),
    .key_mon      (key_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // key code receiver
  initial begin
    key_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        key_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        key_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        key_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  task automatic send_scan(input logic [4:0] raw, input logic [11:0] ax,
                           input logic [11:0] ay);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      scan_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    scan_ch.valid       <= 1'b1;
    scan_ch.raw_buttons <= raw;
    scan_ch.axis_x      <= ax;
    scan_ch.axis_y      <= ay;
    do @(posedge clk_i); while (scan_ch.ready !== 1'b1);
  endtask

  // wait until every due key code has come out and the pipeline is empty
  task automatic settle();
    scan_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
  endtask

  task automatic load_settings(input logic with_spare);
    settle();
    put_reg(CfgPressStep, {8'd0, settings.press_step});
    put_reg(CfgReleaseStep, {8'd0, settings.release_step});
    put_reg(CfgUpperPressLevel, {4'd0, settings.upper_press_level});
    put_reg(CfgUpperReleaseLevel, {4'd0, settings.upper_release_level});
    put_reg(CfgLowerPressLevel, {4'd0, settings.lower_press_level});
    put_reg(CfgLowerReleaseLevel, {4'd0, settings.lower_release_level});
    put_reg(CfgRepeatDelay, settings.repeat_delay);
    put_reg(CfgRepeatPeriod, settings.repeat_period);
    // unknown index, must be ignored
    if (with_spare) put_reg(CfgSpare, 16'($urandom_range(0, 65535)));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_levels(input int unsigned up, input int unsigned ur,
                            input int unsigned lp, input int unsigned lr);
    settings.upper_press_level   = 12'(up);
    settings.upper_release_level = 12'(ur);
    settings.lower_press_level   = 12'(lp);
    settings.lower_release_level = 12'(lr);
  endtask

  task automatic set_timing(input int unsigned ps, input int unsigned rs,
                            input int unsigned dly, input int unsigned per);
    settings.press_step    = 8'(ps);
    settings.release_step  = 8'(rs);
    settings.repeat_delay  = 16'(dly);
    settings.repeat_period = 16'(per);
  endtask

  task automatic pick_settings();
    int unsigned lp;
    int unsigned ur;
    set_timing($urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 10),
               $urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 10),
               $urandom_range(1, 12), $urandom_range(1, 6));
    if ($urandom_range(0, 3) == 0) begin
      set_levels($urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 4095));
    end else begin
      lp = $urandom_range(200, 1800);
      ur = $urandom_range(2200, 3400);
      set_levels(ur + $urandom_range(0, 600), ur, lp, lp + $urandom_range(0, 400));
    end
  endtask

  function automatic logic [11:0] pick_axis();
    int v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 40);
      1: v = $urandom_range(4055, 4095);
      2: v = int'(settings.upper_press_level) + int'($urandom_range(0, 4)) - 2;
      3: v = int'(settings.upper_release_level) + int'($urandom_range(0, 4)) - 2;
      4: v = int'(settings.lower_press_level) + int'($urandom_range(0, 4)) - 2;
      5: v = int'(settings.lower_release_level) + int'($urandom_range(0, 4)) - 2;
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // buttons held in runs with occasional contact bounce, stick mostly steady
  task automatic next_scan();
    logic [4:0] raw;
    if (run_left == 0) begin
      pattern  = 5'($urandom_range(0, 31));
      run_left = $urandom_range(1, 24);
    end
    run_left--;
    raw = pattern;
    if ($urandom_range(0, 7) == 0) raw = raw ^ (5'd1 << $urandom_range(0, 4));
    if ($urandom_range(0, 3) == 0) stick_x = pick_axis();
    if ($urandom_range(0, 3) == 0) stick_y = pick_axis();
    send_scan(raw, stick_x, stick_y);
  endtask

  initial begin
    scan_ch.valid       = 1'b0;
    scan_ch.raw_buttons = 5'd0;
    scan_ch.axis_x      = 12'd0;
    scan_ch.axis_y      = 12'd0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CfgPressStep;
    cfg_ch.data         = 16'd0;
    pattern             = 5'd0;
    run_left            = 0;
    stick_x             = 12'd2048;
    stick_y             = 12'd2048;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: only the stick reacts at once
    send_scan(5'h00, 12'd2048, 12'd2048);
    send_scan(5'h1F, 12'd4095, 12'd0);
    send_scan(5'h00, 12'd0, 12'd4095);

    // fastest debounce, repeat on every tick, thresholds hit exactly
    set_timing(255, 255, 1, 1);
    set_levels(3000, 2600, 1000, 1400);
    load_settings(1'b1);
    send_scan(5'h1F, 12'd4095, 12'd4095);
    send_scan(5'h1F, 12'd4095, 12'd4095);
    send_scan(5'h15, 12'd3000, 12'd2600);
    send_scan(5'h0A, 12'd3001, 12'd2599);
    send_scan(5'h00, 12'd1000, 12'd1400);
    send_scan(5'h00, 12'd999, 12'd1401);

    // overlapping thresholds, clear wins; longest repeat delay and period
    set_timing(1, 255, 65535, 65535);
    set_levels(1000, 3000, 3000, 1000);
    load_settings(1'b0);
    send_scan(5'h00, 12'd2000, 12'd2000);
    send_scan(5'h00, 12'd4095, 12'd0);
    send_scan(5'h1F, 12'd0, 12'd4095);
    send_scan(5'h1F, 12'd2000, 12'd2000);

    // thresholds at the ends of the range, stick state frozen
    set_timing(8, 3, 2, 3);
    set_levels(4095, 0, 0, 4095);
    load_settings(1'b0);
    send_scan(5'h1F, 12'd4095, 12'd0);
    send_scan(5'h1F, 12'd0, 12'd4095);
    send_scan(5'h1B, 12'd2048, 12'd2048);
    repeat (4) send_scan(5'h00, 12'd4095, 12'd4095);

    for (int p = 0; p < PhaseCount; p++) begin
      pick_settings();
      case (p)
        1: set_timing(1, 1, 65535, 65535);
        2: set_levels(4095, 0, 0, 4095);
        3: begin
          set_timing(255, 255, 1, 1);
          set_levels(3000, 2600, 1000, 1400);
        end
        default: ;
      endcase
      if (p == PhaseCount - 1) quiet = 1'b1;
      load_settings(p == 2);
      if (p == 3) begin
        // receiver holds off while every held key repeats each tick
        hold_req = 1'b1;
        repeat (FloodItems) begin
          send_scan(5'($urandom_range(24, 31)), $urandom_range(0, 1) ? 12'd4095 : 12'd0,
                    12'($urandom_range(0, 4095)));
        end
      end
      repeat (ItemsPerPhase) next_scan();
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- keypad_debounce_autorepeat_scanner_top.f -----
rtl/core/kdas_pkg.sv
rtl/core/kdas_if.sv
rtl/core/kdas_cfg.sv
rtl/core/kdas_core.sv
rtl/core/kdas_ser.sv
rtl/core/keypad_debounce_autorepeat_scanner_top.sv
verif/key_code_checker.sv
verif/tb_top.sv
